// ----- rtl/qspd_pkg.sv -----
package qspd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Escape tracking stages.
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX1 = 2'd2;

  // Characters with a special meaning in a query string.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Largest number of results that one input byte can cause.
  localparam int unsigned MAX_RES = 4;

  // One result: kind and decoded byte.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [2:0]           cnt;
    res_t [MAX_RES-1:0]   ent;
  } batch_t;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Nibble value of a hex digit; zero for anything else.
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ----- rtl/qspd_decode.sv -----
module qspd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_end_of_string,
  input  logic               batch_ready,
  output logic               batch_valid,
  output qspd_pkg::batch_t   batch
);

  // Input register.
  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;
  logic       eos_r;

  // Parser state.
  logic       so_r, so_nxt;
  logic       ivp_r, ivp_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;

  logic in_accept;
  logic move;

  assign in_stall    = in_v_r && !batch_ready;
  assign in_accept   = in_valid && !in_stall;
  assign move        = in_v_r && batch_ready;
  assign batch_valid = in_v_r;
  assign in_v_nxt    = in_accept || (in_v_r && !batch_ready);

  // Expand the registered byte into its list of results and the next state.
  always_comb begin
    logic [1:0] cur;
    qspd_pkg::batch_t b;
    logic hx;
    b        = '0;
    so_nxt   = so_r;
    ivp_nxt  = ivp_r;
    esc_nxt  = ((esc_r == qspd_pkg::ESC_PCT) || (esc_r == qspd_pkg::ESC_HEX1)) ?
               esc_r : qspd_pkg::ESC_NONE;
    held_nxt = held_r;
    hx       = qspd_pkg::is_hex(byte_r);
    cur      = ivp_nxt ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_NAME;

    if (byte_r == qspd_pkg::CH_AMP) begin
      // Separator: flush a pending escape, then close the pair.
      if (esc_nxt != qspd_pkg::ESC_NONE) begin
        b.ent[b.cnt[1:0]] = '{kind: cur, data: qspd_pkg::CH_PCT};
        b.cnt = b.cnt + 3'd1;
      end
      if (esc_nxt == qspd_pkg::ESC_HEX1) begin
        b.ent[b.cnt[1:0]] = '{kind: cur, data: held_nxt};
        b.cnt = b.cnt + 3'd1;
      end
      esc_nxt  = qspd_pkg::ESC_NONE;
      held_nxt = 8'd0;
      if (so_nxt) begin
        b.ent[b.cnt[1:0]] = '{kind: qspd_pkg::KIND_END, data: 8'd0};
        b.cnt = b.cnt + 3'd1;
      end
      so_nxt  = 1'b0;
      ivp_nxt = 1'b0;
    end else begin
      so_nxt = 1'b1;
      if ((esc_nxt == qspd_pkg::ESC_PCT) && hx) begin
        // First hex digit of an escape is held.
        held_nxt = byte_r;
        esc_nxt  = qspd_pkg::ESC_HEX1;
      end else if ((esc_nxt == qspd_pkg::ESC_HEX1) && hx) begin
        // Second hex digit completes the escape.
        b.ent[b.cnt[1:0]] = '{kind: cur,
                              data: {qspd_pkg::hex_nib(held_nxt), qspd_pkg::hex_nib(byte_r)}};
        b.cnt = b.cnt + 3'd1;
        esc_nxt  = qspd_pkg::ESC_NONE;
        held_nxt = 8'd0;
      end else begin
        // A broken escape passes literally, then the byte is decoded on its own.
        if (esc_nxt != qspd_pkg::ESC_NONE) begin
          b.ent[b.cnt[1:0]] = '{kind: cur, data: qspd_pkg::CH_PCT};
          b.cnt = b.cnt + 3'd1;
        end
        if (esc_nxt == qspd_pkg::ESC_HEX1) begin
          b.ent[b.cnt[1:0]] = '{kind: cur, data: held_nxt};
          b.cnt = b.cnt + 3'd1;
        end
        esc_nxt  = qspd_pkg::ESC_NONE;
        held_nxt = 8'd0;
        if (!ivp_nxt && (byte_r == qspd_pkg::CH_EQ)) begin
          ivp_nxt = 1'b1;
        end else if (byte_r == qspd_pkg::CH_PLUS) begin
          b.ent[b.cnt[1:0]] = '{kind: cur, data: qspd_pkg::CH_SPACE};
          b.cnt = b.cnt + 3'd1;
        end else if (byte_r == qspd_pkg::CH_PCT) begin
          esc_nxt = qspd_pkg::ESC_PCT;
        end else begin
          b.ent[b.cnt[1:0]] = '{kind: cur, data: byte_r};
          b.cnt = b.cnt + 3'd1;
        end
      end
    end

    // End of string: flush, close an open pair and return to the reset state.
    if (eos_r) begin
      cur = ivp_nxt ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_NAME;
      if (esc_nxt != qspd_pkg::ESC_NONE) begin
        b.ent[b.cnt[1:0]] = '{kind: cur, data: qspd_pkg::CH_PCT};
        b.cnt = b.cnt + 3'd1;
      end
      if (esc_nxt == qspd_pkg::ESC_HEX1) begin
        b.ent[b.cnt[1:0]] = '{kind: cur, data: held_nxt};
        b.cnt = b.cnt + 3'd1;
      end
      esc_nxt  = qspd_pkg::ESC_NONE;
      held_nxt = 8'd0;
      if (so_nxt) begin
        b.ent[b.cnt[1:0]] = '{kind: qspd_pkg::KIND_END, data: 8'd0};
        b.cnt = b.cnt + 3'd1;
      end
      so_nxt  = 1'b0;
      ivp_nxt = 1'b0;
    end
    batch = b;
  end

  // Input register: loads on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    if (in_accept) begin
      byte_r <= in_byte;
      eos_r  <= in_end_of_string;
    end
  end

  // Parser state advances when the registered byte moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r   <= 1'b0;
      ivp_r  <= 1'b0;
      esc_r  <= qspd_pkg::ESC_NONE;
      held_r <= 8'd0;
    end else if (move) begin
      so_r   <= so_nxt;
      ivp_r  <= ivp_nxt;
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
    end
  end

  // A pending escape only exists inside an open segment.
  a_esc_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (esc_r != qspd_pkg::ESC_NONE) |-> so_r)
    else $error("escape pending outside a segment");

  // The held digit is cleared whenever no digit is waiting.
  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (esc_r != qspd_pkg::ESC_HEX1) |-> (held_r == 8'd0))
    else $error("held hex digit not cleared");

  // The value part is only entered inside an open segment.
  a_value_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    ivp_r |-> so_r)
    else $error("value part outside a segment");

endmodule

// ----- rtl/qspd_obuf.sv -----
module qspd_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             batch_valid,
  output logic             batch_ready,
  input  qspd_pkg::batch_t batch,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_item_kind,
  output logic [7:0]       out_byte,
  output logic             out_run_last
);

  logic                           v_r, v_nxt;
  logic [1:0]                     idx_r, idx_nxt;
  logic [1:0]                     last_r;
  qspd_pkg::res_t [qspd_pkg::MAX_RES-1:0] ent_r;
  logic                           out_fire;
  logic                           load;

  assign out_fire    = v_r && !out_stall;
  assign batch_ready = !v_r || (out_fire && (idx_r == last_r));
  assign load        = batch_valid && batch_ready && (batch.cnt != 3'd0);

  assign out_valid     = v_r;
  assign out_item_kind = ent_r[idx_r].kind;
  assign out_byte      = ent_r[idx_r].data;
  assign out_run_last  = (idx_r == last_r);

  // Step through the held results, one per output transfer.
  always_comb begin
    v_nxt   = v_r;
    idx_nxt = idx_r;
    if (batch_ready) begin
      v_nxt   = load;
      idx_nxt = 2'd0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      v_r   <= v_nxt;
      idx_r <= idx_nxt;
    end
    if (load) begin
      ent_r  <= batch.ent;
      last_r <= 2'(batch.cnt - 3'd1);
    end
  end

  // The read position never passes the last held result.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (idx_r <= last_r))
    else $error("result index past last entry");

  // A stalled result keeps its position and its contents.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && out_stall) |=> (v_r && $stable(idx_r) && $stable(ent_r)))
    else $error("stalled result changed");

  // One input byte never offers more results than the buffer holds.
  a_batch_count: assert property (@(posedge clk) disable iff (!rst_n)
    batch_valid |-> (batch.cnt <= 3'(qspd_pkg::MAX_RES)))
    else $error("batch count out of range");

endmodule

// ----- rtl/query_string_pair_decoder_unit.sv -----
// Query string pair decoder.
// Input channel: one raw byte of a query string per transfer (in_byte), with
// in_end_of_string set on the final byte. Result channel: decoded name bytes,
// value bytes and end-of-pair markers (out_item_kind, out_byte), with
// out_run_last set on the last result caused by one input byte. An input
// byte may cause zero to four results.
// A byte passes from the input register into the result buffer, which gives
// its results. Throughput: one byte per cycle while each byte causes at most
// one result and out_stall stays low; a byte with more results holds the input
// until the result buffer has sent them all, one result per transfer.
// The input side stays open while a result waits, since the input register
// and the result buffer are separate stages.
// When the receiver asserts out_stall, the current result holds and the input
// stalls once both stages are full.
// Reset (rst_n low, synchronous) empties both stages and returns the parser
// to the start of a new string. The end of each string also returns it there.
module query_string_pair_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  logic             batch_valid;
  logic             batch_ready;
  qspd_pkg::batch_t batch;

  // Input register, parser state and result expansion.
  qspd_decode u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .batch_ready      (batch_ready),
    .batch_valid      (batch_valid),
    .batch            (batch)
  );

  // Result buffer, one transfer per result.
  qspd_obuf u_obuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .batch_valid   (batch_valid),
    .batch_ready   (batch_ready),
    .batch         (batch),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item_kind (out_item_kind),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last)
  );

endmodule
